/* hw/rtl/ordered_process_queue_macros.svh */
// ----------------------------------------------------------------------------
// ordered_process_queue_macros.svh
// Assertion macros for the ordered process queue. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_PROCESS_QUEUE_MACROS_SVH
`define ORDERED_PROCESS_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define OPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every clock edge, reset included
`define OPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OPQ_ASSERT(lbl, prop, msg)
`define OPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/opq_pkg.sv */
// ----------------------------------------------------------------------------
// opq_pkg
// Shared types and constants of the ordered process queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package opq_pkg;

	// default sizes
	localparam int DEPTH_DEF    = 16;
	localparam int PID_BITS_DEF = 16;

	// operation codes of the func field
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_POS_LARGE = 3'd3,
		ST_FULL      = 3'd4
	} opq_status_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic ins_en;     // insert accepted and legal
		logic rem_en;     // remove accepted on a non-empty queue
		logic head_mode;  // remove takes the head (pid 0)
	} opq_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/opq_cell.sv */
// ----------------------------------------------------------------------------
// opq_cell
// One slot of the queue. Holds a PID, matches it against the key, and
// shifts towards the tail on insert or towards the head on remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opq_cell #(
	parameter int INDEX    = 0,
	parameter int PID_BITS = opq_pkg::PID_BITS_DEF,
	parameter int CNT_W    = 5
) (
	input  wire                   clk,
	input  opq_pkg::opq_cmd_t     cmd,
	input  wire  [CNT_W-1:0]      count,
	input  wire  [CNT_W-1:0]      ins_pos,
	input  wire  [PID_BITS-1:0]   key,
	input  wire  [PID_BITS-1:0]   left_pid,
	input  wire  [PID_BITS-1:0]   right_pid,
	input  wire                   past_in,
	input  wire  [PID_BITS-1:0]   rem_in,
	output logic [PID_BITS-1:0]   pid,
	output logic [PID_BITS-1:0]   pid_next,
	output logic                  past_out,
	output logic [PID_BITS-1:0]   rem_out
);

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic [PID_BITS-1:0] pid_q;
	logic                in_range;
	logic                match;
	logic                hit;

	// first-match detection: past_in says a cell nearer the head already hit
	always_comb begin
		in_range = (IDX < count);
		match    = cmd.head_mode ? (INDEX == 0) : (pid_q == key);
		hit      = cmd.rem_en & in_range & match & ~past_in;
		past_out = past_in | hit;
		rem_out  = rem_in | (hit ? pid_q : '0);
	end

	// next slot contents
	always_comb begin
		pid_next = pid_q;
		if (cmd.ins_en) begin
			if (IDX > ins_pos) begin
				pid_next = left_pid;
			end else if (IDX == ins_pos) begin
				pid_next = key;
			end
		end else if (past_out) begin
			pid_next = right_pid;
		end
	end

	// slot register, payload only
	always_ff @(posedge clk) begin
		pid_q <= pid_next;
	end

	assign pid = pid_q;

endmodule

`default_nettype wire

/* hw/rtl/ordered_process_queue.sv */
// ----------------------------------------------------------------------------
// ordered_process_queue
// Ordered queue of process identifiers with positional insert and
// first-match remove, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item: func, pid, at_tail
//   and position. Output channel (out_valid / out_stall) returns one result
//   item per input item: status, removed_pid, entry_count, head_pid and
//   is_empty.
//   Every cell compares and moves its slot in the same cycle, so the result
//   of an item is in the output register in the cycle after acceptance, and
//   one item per cycle is taken while results are drained.
//   The cycle is set by the match ripple through the row of cells.
//   The output register parts the channels: a new item is taken while the
//   last result is taken in the same cycle. If the receiver stalls with a
//   result waiting, in_stall rises until the result goes.
//   Reset empties the queue (count to zero) and drops any waiting result;
//   the slot contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_process_queue #(
	parameter int DEPTH    = opq_pkg::DEPTH_DEF,
	parameter int PID_BITS = opq_pkg::PID_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// input channel
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         func,
	input  wire  [15:0] pid,
	input  wire         at_tail,
	input  wire  [4:0]  position,
	// output channel
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  status,
	output logic [15:0] removed_pid,
	output logic [4:0]  entry_count,
	output logic [15:0] head_pid,
	output logic        is_empty
);

`include "ordered_process_queue_macros.svh"

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	logic                 accept;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_next;
	logic [PID_BITS-1:0]  key;
	logic [CMP_W-1:0]     pos_w;
	logic [CNT_W-1:0]     ins_pos;
	logic                 found;
	opq_pkg::opq_cmd_t    cmd;
	opq_pkg::opq_status_t status_d;

	logic [PID_BITS-1:0]  cell_pid  [DEPTH];
	logic [PID_BITS-1:0]  cell_next [DEPTH];
	logic                 past      [DEPTH+1];
	logic [PID_BITS-1:0]  rem       [DEPTH+1];

	logic                 out_valid_q;
	opq_pkg::opq_status_t status_q;
	logic [15:0]          removed_q;
	logic [4:0]           count_out_q;
	logic [15:0]          head_q;
	logic                 empty_q;

	// handshake
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// decode of the item
	always_comb begin
		key   = PID_BITS'(pid);
		pos_w = at_tail ? CMP_W'(count_q) : CMP_W'(position);
		ins_pos = CNT_W'(pos_w);
		cmd.ins_en    = accept & (func == opq_pkg::FUNC_INSERT)
			& (pos_w <= CMP_W'(count_q)) & (count_q != CNT_W'(DEPTH));
		cmd.rem_en    = accept & (func == opq_pkg::FUNC_REMOVE) & (count_q != '0);
		cmd.head_mode = (key == '0);
	end

	// row of cells
	assign past[0] = 1'b0;
	assign rem[0]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [PID_BITS-1:0] left_pid;
		logic [PID_BITS-1:0] right_pid;

		if (i == 0) begin : g_head
			assign left_pid = key;
		end else begin : g_mid
			assign left_pid = cell_pid[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_pid = cell_pid[i];
		end else begin : g_body
			assign right_pid = cell_pid[i+1];
		end

		opq_cell #(
			.INDEX    (i),
			.PID_BITS (PID_BITS),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.count     (count_q),
			.ins_pos   (ins_pos),
			.key       (key),
			.left_pid  (left_pid),
			.right_pid (right_pid),
			.past_in   (past[i]),
			.rem_in    (rem[i]),
			.pid       (cell_pid[i]),
			.pid_next  (cell_next[i]),
			.past_out  (past[i+1]),
			.rem_out   (rem[i+1])
		);
	end

	assign found = past[DEPTH];

	// status and new count
	always_comb begin
		count_next = count_q;
		if (func == opq_pkg::FUNC_INSERT) begin
			if (pos_w > CMP_W'(count_q)) begin
				status_d = opq_pkg::ST_POS_LARGE;
			end else if (count_q == CNT_W'(DEPTH)) begin
				status_d = opq_pkg::ST_FULL;
			end else begin
				status_d   = opq_pkg::ST_OK;
				count_next = count_q + CNT_W'(1);
			end
		end else begin
			if (count_q == '0) begin
				status_d = opq_pkg::ST_EMPTY;
			end else if (!found) begin
				status_d = opq_pkg::ST_NOT_FOUND;
			end else begin
				status_d   = opq_pkg::ST_OK;
				count_next = count_q - CNT_W'(1);
			end
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			removed_q   <= 16'(rem[DEPTH]);
			count_out_q <= 5'(count_next);
			head_q      <= (count_next != '0) ? 16'(cell_next[0]) : '0;
			empty_q     <= (count_next == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign removed_pid = removed_q;
	assign entry_count = count_out_q;
	assign head_pid    = head_q;
	assign is_empty    = empty_q;

	// checks
	`OPQ_ASSERT_ALWAYS(a_count_bound, !arst_n || count_q <= CNT_W'(DEPTH), "occupancy above depth")
	`OPQ_ASSERT(a_rem_dec, (cmd.rem_en && found) |=> (count_q == $past(count_q) - CNT_W'(1)), "remove hit did not lower count")
	`OPQ_ASSERT(a_ins_inc, cmd.ins_en |=> (count_q == $past(count_q) + CNT_W'(1)), "insert did not raise count")
	`OPQ_ASSERT(a_fail_zero, (out_valid_q && status_q != opq_pkg::ST_OK) |-> (removed_q == '0), "failed item reports a removed pid")

endmodule

`default_nettype wire
